FILE: rtl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, codes and helpers of the CRC-8 frame receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned HUNT_W  = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned DEF_MAX_PAYLOAD = 32;

  localparam logic [HUNT_W-1:0] HUNT_LIMIT = 10'd1000;
  localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT   = 8'h00;
  localparam logic [LEN_W-1:0]  LEN_SAT    = 6'd63;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 6'd32;
  localparam logic [TMO_W-1:0]  RST_TIMEOUT_MS  = 16'd100;
  localparam logic [BYTE_W-1:0] RST_HEADER_BYTE = 8'hAA;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADHDR  = 3'd2;
  localparam logic [STAT_W-1:0] ST_LARGE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_CRC     = 3'd4;

  // Input item kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TYPE,
    S_LEN,
    S_DATA,
    S_CHECK,
    S_READ,
    S_LOAD
  } state_t;

  typedef enum logic [2:0] {
    EM_TIMEOUT,
    EM_BADHDR,
    EM_LARGE,
    EM_CRC,
    EM_OKZERO,
    EM_DATA
  } emit_t;

  // Controller to datapath
  typedef struct packed {
    logic  byte_seen;
    logic  tick_inc;
    logic  tick_clr;
    logic  hunt_inc;
    logic  hunt_clr;
    logic  start_frame;
    logic  clr_frame;
    logic  take_type;
    logic  take_len;
    logic  take_data;
    logic  take_chk;
    logic  rd_start;
    logic  rd_issue;
    logic  emit;
    emit_t emit_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic hunt_over;
    logic hdr_match;
    logic timeout_hit;
    logic too_large;
    logic len_zero;
    logic data_last;
    logic crc_match;
    logic frame_len_zero;
    logic rd_last;
  } sts_t;

  // One byte of CRC-8, MSB first, no reflection
  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/crc8fr_ram.sv
// ----------------------------------------------------------------------------
// crc8fr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crc8fr_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/crc8fr_ctrl.sv
// ----------------------------------------------------------------------------
// crc8fr_ctrl
// Frame state machine: walks header, type, length, payload and checksum,
// then steps the buffer readout.
// ----------------------------------------------------------------------------
module crc8fr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  crc8fr_pkg::sts_t   sts,
  output crc8fr_pkg::cmd_t   cmd
);
  import crc8fr_pkg::*;

  state_t state, state_next;
  logic   in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_kind = EM_DATA;
    in_ready   = 1'b0;
    in_fire    = 1'b0;

    unique case (state)
      S_IDLE, S_TYPE, S_LEN, S_DATA, S_CHECK: begin
        in_ready = sts.out_free;
        in_fire  = in_valid && sts.out_free;
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EM_DATA;
          state_next    = sts.rd_last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (in_fire) begin
      if (req_type == REQ_TICK) begin
        if (state != S_IDLE) begin
          if (sts.timeout_hit) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EM_TIMEOUT;
            cmd.tick_clr  = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.tick_inc = 1'b1;
          end
        end
      end else begin
        cmd.byte_seen = 1'b1;
        priority case (state)
          S_IDLE: begin
            cmd.hunt_inc = 1'b1;
            if (sts.hunt_over) begin
              cmd.hunt_clr  = 1'b1;
              cmd.clr_frame = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_kind = EM_BADHDR;
            end else if (sts.hdr_match) begin
              cmd.hunt_clr    = 1'b1;
              cmd.start_frame = 1'b1;
              state_next      = S_TYPE;
            end
          end
          S_TYPE: begin
            cmd.take_type = 1'b1;
            state_next    = S_LEN;
          end
          S_LEN: begin
            if (sts.too_large) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = EM_LARGE;
              state_next    = S_IDLE;
            end else begin
              cmd.take_len = 1'b1;
              state_next   = sts.len_zero ? S_CHECK : S_DATA;
            end
          end
          S_DATA: begin
            cmd.take_data = 1'b1;
            if (sts.data_last) begin
              state_next = S_CHECK;
            end
          end
          default: begin
            // checksum byte
            cmd.take_chk = 1'b1;
            state_next   = S_IDLE;
            if (!sts.crc_match) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = EM_CRC;
            end else if (sts.frame_len_zero) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = EM_OKZERO;
            end else begin
              cmd.rd_start = 1'b1;
              state_next   = S_READ;
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: rtl/crc8fr_dp.sv
// ----------------------------------------------------------------------------
// crc8fr_dp
// Datapath: configuration registers, frame registers, running CRC, payload
// buffer and the result register.
// ----------------------------------------------------------------------------
module crc8fr_dp #(
  parameter int unsigned MAX_PAYLOAD = crc8fr_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [crc8fr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crc8fr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [crc8fr_pkg::BYTE_W-1:0]         rx_byte,
  input  crc8fr_pkg::cmd_t                      cmd,
  output crc8fr_pkg::sts_t                      sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [crc8fr_pkg::STAT_W-1:0]         status,
  output logic [crc8fr_pkg::BYTE_W-1:0]         cmd_type,
  output logic [crc8fr_pkg::LEN_W-1:0]          payload_len,
  output logic [crc8fr_pkg::IDX_W-1:0]          byte_index,
  output logic [crc8fr_pkg::BYTE_W-1:0]         payload_byte,
  output logic [crc8fr_pkg::BYTE_W-1:0]         rx_checksum,
  output logic                                  last
);
  import crc8fr_pkg::*;

  localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_PAYLOAD);

  // configuration
  logic [LEN_W-1:0]  max_payload;
  logic [TMO_W-1:0]  timeout_ms;
  logic [BYTE_W-1:0] header_byte;

  // frame state
  logic [HUNT_W-1:0] hunt_count;
  logic [TMO_W-1:0]  quiet_ticks;
  logic [BYTE_W-1:0] frame_type;
  logic [LEN_W-1:0]  frame_len;
  logic [LEN_W-1:0]  bytes_taken;
  logic [BYTE_W-1:0] running_crc;
  logic [BYTE_W-1:0] chk;
  logic [LEN_W-1:0]  rd_idx;

  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] limit;
  logic [BYTE_W-1:0] crc_next;
  logic [HUNT_W-1:0] hunt_next;
  logic [TMO_W:0]    quiet_next;
  logic              out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= RST_MAX_PAYLOAD;
      timeout_ms  <= RST_TIMEOUT_MS;
      header_byte <= RST_HEADER_BYTE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_PAYLOAD: max_payload <= cfg_data[LEN_W-1:0];
        REG_TIMEOUT_MS:  timeout_ms  <= cfg_data[TMO_W-1:0];
        REG_HEADER_BYTE: header_byte <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit      = (BYTE_W'(max_payload) > MaxLen) ? MaxLen : BYTE_W'(max_payload);
  assign crc_next   = crc8_update(cmd.start_frame ? CRC_INIT : running_crc, rx_byte);
  assign hunt_next  = hunt_count + 1'b1;
  assign quiet_next = {1'b0, quiet_ticks} + 1'b1;
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    sts                = '0;
    sts.out_free       = out_free;
    sts.hunt_over      = hunt_next > HUNT_LIMIT;
    sts.hdr_match      = rx_byte == header_byte;
    sts.timeout_hit    = quiet_next > {1'b0, timeout_ms};
    sts.too_large      = rx_byte > limit;
    sts.len_zero       = rx_byte == '0;
    sts.data_last      = ((LEN_W + 1)'(bytes_taken) + 1'b1) >= (LEN_W + 1)'(frame_len);
    sts.crc_match      = running_crc == rx_byte;
    sts.frame_len_zero = frame_len == '0;
    sts.rd_last        = ((LEN_W + 1)'(rd_idx) + 1'b1) == (LEN_W + 1)'(frame_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_count  <= '0;
      quiet_ticks <= '0;
      frame_type  <= '0;
      frame_len   <= '0;
      bytes_taken <= '0;
      running_crc <= '0;
      rd_idx      <= '0;
    end else begin
      if (cmd.hunt_clr) begin
        hunt_count <= '0;
      end else if (cmd.hunt_inc) begin
        hunt_count <= hunt_next;
      end

      if (cmd.byte_seen || cmd.tick_clr) begin
        quiet_ticks <= '0;
      end else if (cmd.tick_inc) begin
        quiet_ticks <= quiet_next[TMO_W-1:0];
      end

      if (cmd.start_frame || cmd.clr_frame) begin
        frame_type <= '0;
        frame_len  <= '0;
      end
      if (cmd.start_frame) begin
        bytes_taken <= '0;
      end
      if (cmd.start_frame || cmd.take_type || cmd.take_len || cmd.take_data) begin
        running_crc <= crc_next;
      end
      if (cmd.take_type) begin
        frame_type <= rx_byte;
      end
      if (cmd.take_len) begin
        frame_len   <= rx_byte[LEN_W-1:0];
        bytes_taken <= '0;
      end
      if (cmd.take_data) begin
        bytes_taken <= bytes_taken + 1'b1;
      end

      if (cmd.rd_start) begin
        rd_idx <= '0;
      end else if (cmd.emit && cmd.emit_kind == EM_DATA) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_chk) begin
      chk <= rx_byte;
    end
  end

  crc8fr_ram #(
    .WIDTH  (BYTE_W),
    .DEPTH  (MAX_PAYLOAD),
    .ADDR_W (ADDR_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (cmd.take_data && ((LEN_W + 1)'(bytes_taken) < (LEN_W + 1)'(MAX_PAYLOAD))),
    .wr_addr (bytes_taken[ADDR_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cmd_type     <= frame_type;
      payload_len  <= frame_len;
      byte_index   <= '0;
      payload_byte <= '0;
      rx_checksum  <= '0;
      last         <= 1'b1;
      unique case (cmd.emit_kind)
        EM_TIMEOUT: status <= ST_TIMEOUT;
        EM_BADHDR: begin
          status      <= ST_BADHDR;
          cmd_type    <= '0;
          payload_len <= '0;
        end
        EM_LARGE: begin
          status      <= ST_LARGE;
          payload_len <= (rx_byte > BYTE_W'(LEN_SAT)) ? LEN_SAT : rx_byte[LEN_W-1:0];
        end
        EM_CRC: begin
          status      <= ST_CRC;
          rx_checksum <= rx_byte;
        end
        EM_OKZERO: begin
          status      <= ST_OK;
          rx_checksum <= rx_byte;
        end
        EM_DATA: begin
          status       <= ST_OK;
          byte_index   <= rd_idx[IDX_W-1:0];
          payload_byte <= rd_data;
          rx_checksum  <= chk;
          last         <= sts.rd_last;
        end
        default: status <= ST_OK;
      endcase
    end
  end

endmodule

FILE: rtl/crc8_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver_core
// Byte-serial frame receiver with header hunt, length check and CRC-8.
// ----------------------------------------------------------------------------
// Each input transfer is either a received byte or a one millisecond tick,
// and is taken whenever the result register is free, outside readout. The
// block hunts for header_byte (reporting bad header after more than 1000
// bytes without one), then takes type, length, payload and checksum. CRC-8
// uses polynomial 0x07, initial value 0, MSB first, over header, type,
// length and payload. A good frame is read back from the payload buffer one
// result per payload byte, or a single result if empty; each buffer entry
// takes a registered RAM read, then a result load that waits for a free
// result register; no input is taken during readout. Errors (timeout, bad
// header, payload too large, CRC mismatch) give one result each, with last
// set, and return the receiver to the hunt. Configuration writes are always
// taken and should only be issued while the block is quiet.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_core #(
  parameter int unsigned MAX_PAYLOAD = crc8fr_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                              clk,
  input  logic                              rst,
  // input items
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [crc8fr_pkg::BYTE_W-1:0]     rx_byte,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [crc8fr_pkg::STAT_W-1:0]     status,
  output logic [crc8fr_pkg::BYTE_W-1:0]     cmd_type,
  output logic [crc8fr_pkg::LEN_W-1:0]      payload_len,
  output logic [crc8fr_pkg::IDX_W-1:0]      byte_index,
  output logic [crc8fr_pkg::BYTE_W-1:0]     payload_byte,
  output logic [crc8fr_pkg::BYTE_W-1:0]     rx_checksum,
  output logic                              last,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crc8fr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc8fr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crc8fr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence the frame and drive the datapath
  crc8fr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold frame state, buffer the payload and present results
  crc8fr_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (rx_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd_type     (cmd_type),
    .payload_len  (payload_len),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .rx_checksum  (rx_checksum),
    .last         (last)
  );

endmodule

FILE: bench/crc8_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_core testbench
// Sends received bytes and millisecond ticks into the receiver, tracks the
// expected frame results in a behavioural copy of the receiver and checks
// every result transfer, field by field, while both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import crc8fr_pkg::*;

  localparam int unsigned PAYLOAD_DEPTH = DEF_MAX_PAYLOAD;
  // Quiet cycles allowed before the run is abandoned. The longest honest
  // stretch without any transfer is a receiver stall, a sender gap, a settle
  // pause or the closing hold-off, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT   = 2000;
  // Readout walks the buffer one byte at a time; once the last result
  // is out the block is back in the hunt, so a short settle is plenty.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] cmd;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] chk;
    logic              fin;
  } frame_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  req_type  = REQ_BYTE;
  logic [BYTE_W-1:0]     rx_byte   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STAT_W-1:0]     status;
  logic [BYTE_W-1:0]     cmd_type;
  logic [LEN_W-1:0]      payload_len;
  logic [IDX_W-1:0]      byte_index;
  logic [BYTE_W-1:0]     payload_byte;
  logic [BYTE_W-1:0]     rx_checksum;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Register copies, as last written
  logic [LEN_W-1:0]  reg_max_payload = RST_MAX_PAYLOAD;
  logic [TMO_W-1:0]  reg_timeout     = RST_TIMEOUT_MS;
  logic [BYTE_W-1:0] reg_header      = RST_HEADER_BYTE;

  // Receiver state as the bench tracks it
  state_t            rx_phase    = S_IDLE;
  int unsigned       hunt_seen   = 0;
  logic [TMO_W-1:0]  quiet_ticks = '0;
  logic [BYTE_W-1:0] frame_type  = '0;
  logic [LEN_W-1:0]  frame_len   = '0;
  logic [LEN_W-1:0]  bytes_taken = '0;
  logic [BYTE_W-1:0] frame_crc   = '0;
  logic [BYTE_W-1:0] payload_copy [PAYLOAD_DEPTH];

  frame_result_t pending_results [$];
  int unsigned   fail_count  = 0;
  int unsigned   items_taken = 0;
  bit            sender_gaps = 1'b1;
  int unsigned   burst_left  = 0;
  int unsigned   idle_cycles = 0;
  logic [15:0]   ready_pattern = '0;
  int unsigned   ready_hold    = 0;

  crc8_frame_receiver_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd_type     (cmd_type),
    .payload_len  (payload_len),
    .byte_index   (byte_index),
    .payload_byte (payload_byte),
    .rx_checksum  (rx_checksum),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioural tracking of the receiver
  // --------------------------------------------------------------------------

  // Bit-serial CRC-8: shift the message in MSB first, feed back the poly.
  function automatic logic [BYTE_W-1:0] crc8_shift_in(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    logic              fb;
    c = crc;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      fb = c[BYTE_W-1] ^ b[k];
      c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic void expect_result(input logic [STAT_W-1:0] st,
                                        input logic [LEN_W-1:0] len,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] data,
                                        input logic [BYTE_W-1:0] chk,
                                        input logic fin);
    frame_result_t r;
    r.status = st;
    r.cmd    = frame_type;
    r.len    = len;
    r.idx    = idx;
    r.data   = data;
    r.chk    = chk;
    r.fin    = fin;
    pending_results.push_back(r);
  endfunction

  // Advance the tracked receiver by one accepted item and queue the results
  // it causes. Returns 0 for a tick the receiver simply ignores.
  function automatic bit track_item(input logic kind, input logic [BYTE_W-1:0] b);
    logic [TMO_W:0]    q;
    logic [BYTE_W-1:0] lim;
    if (kind == REQ_TICK) begin
      if (rx_phase == S_IDLE) begin
        return 1'b0;
      end
      q = quiet_ticks + 1'b1;
      if (q > reg_timeout) begin
        expect_result(ST_TIMEOUT, frame_len, '0, '0, '0, 1'b1);
        rx_phase    = S_IDLE;
        quiet_ticks = '0;
      end else begin
        quiet_ticks = q[TMO_W-1:0];
      end
      return 1'b1;
    end
    quiet_ticks = '0;
    case (rx_phase)
      S_IDLE: begin
        hunt_seen++;
        if (hunt_seen > HUNT_LIMIT) begin
          hunt_seen  = 0;
          frame_type = '0;
          frame_len  = '0;
          expect_result(ST_BADHDR, '0, '0, '0, '0, 1'b1);
        end else if (b == reg_header) begin
          hunt_seen   = 0;
          frame_type  = '0;
          frame_len   = '0;
          bytes_taken = '0;
          frame_crc   = crc8_shift_in(CRC_INIT, b);
          rx_phase    = S_TYPE;
        end
      end
      S_TYPE: begin
        frame_type = b;
        frame_crc  = crc8_shift_in(frame_crc, b);
        rx_phase   = S_LEN;
      end
      S_LEN: begin
        lim = (reg_max_payload < PAYLOAD_DEPTH) ? reg_max_payload : PAYLOAD_DEPTH;
        if (b > lim) begin
          expect_result(ST_LARGE, (b > LEN_SAT) ? LEN_SAT : b[LEN_W-1:0], '0, '0, '0, 1'b1);
          rx_phase = S_IDLE;
        end else begin
          frame_len   = b[LEN_W-1:0];
          bytes_taken = '0;
          frame_crc   = crc8_shift_in(frame_crc, b);
          rx_phase    = (b == 8'd0) ? S_CHECK : S_DATA;
        end
      end
      S_DATA: begin
        payload_copy[bytes_taken] = b;
        frame_crc   = crc8_shift_in(frame_crc, b);
        bytes_taken = bytes_taken + 1'b1;
        if (bytes_taken >= frame_len) begin
          rx_phase = S_CHECK;
        end
      end
      S_CHECK: begin
        rx_phase = S_IDLE;
        if (frame_crc != b) begin
          expect_result(ST_CRC, frame_len, '0, '0, b, 1'b1);
        end else if (frame_len == '0) begin
          expect_result(ST_OK, '0, '0, '0, b, 1'b1);
        end else begin
          for (int i = 0; i < frame_len; i++) begin
            expect_result(ST_OK, frame_len, IDX_W'(i), payload_copy[i], b,
                          (i + 1 == frame_len));
          end
        end
      end
      default: begin
        rx_phase = S_IDLE;
      end
    endcase
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Send one item. Work in bursts; between bursts, if sender gaps are on, drop valid for a gap.
  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      if (sender_gaps) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= kind;
    rx_byte  <= value;
    do @(posedge clk); while (!in_ready);
    if (track_item(kind, value)) begin
      items_taken++;
    end
  endtask

  // The byte lane carries junk on a tick; it must be ignored.
  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom));
  endtask

  // Hold the sender off until every queued result has been taken.
  task automatic pause_until_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    pause_until_done();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAX_PAYLOAD: reg_max_payload = value[LEN_W-1:0];
      REG_TIMEOUT_MS:  reg_timeout     = value;
      REG_HEADER_BYTE: reg_header      = value[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // Upper bits of the narrow registers carry junk that must be dropped.
  task automatic apply_settings(input logic [LEN_W-1:0] max_len,
                                input logic [TMO_W-1:0] tmo,
                                input logic [BYTE_W-1:0] hdr);
    write_reg(REG_MAX_PAYLOAD, {10'($urandom), max_len});
    write_reg(REG_TIMEOUT_MS, tmo);
    write_reg(REG_HEADER_BYTE, {8'($urandom), hdr});
  endtask

  // Now and then slip in a few ticks, never enough to time the frame out.
  task automatic maybe_ticks();
    int unsigned n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, (reg_timeout < 3) ? reg_timeout : 3);
      repeat (n) send_tick();
    end
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] typ, input int unsigned len,
                            input bit corrupt, input bit all_ones);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] data;
    crc = crc8_shift_in(CRC_INIT, reg_header);
    send_item(REQ_BYTE, reg_header);
    maybe_ticks();
    crc = crc8_shift_in(crc, typ);
    send_item(REQ_BYTE, typ);
    maybe_ticks();
    crc = crc8_shift_in(crc, 8'(len));
    send_item(REQ_BYTE, 8'(len));
    repeat (len) begin
      data = all_ones ? 8'hFF : 8'($urandom);
      crc  = crc8_shift_in(crc, data);
      maybe_ticks();
      send_item(REQ_BYTE, data);
    end
    if (corrupt) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    maybe_ticks();
    send_item(REQ_BYTE, crc);
  endtask

  task automatic send_oversize(input logic [BYTE_W-1:0] len_byte);
    send_item(REQ_BYTE, reg_header);
    send_item(REQ_BYTE, 8'($urandom));
    send_item(REQ_BYTE, len_byte);
  endtask

  // Mostly short payloads, sometimes anything up to the limit, sometimes the
  // limit itself.
  function automatic int unsigned pick_len(input int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return $urandom_range(0, (lim < 8) ? lim : 8);
    end else if (r < 9) begin
      return $urandom_range(0, lim);
    end
    return lim;
  endfunction

  // Mostly well-formed frames with random content; the rest bad checksums, oversize
  // lengths, frames cut short (timed out under short timeouts) and line noise.
  task automatic run_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned lim;
    stop_at = items_taken + n;
    while (items_taken < stop_at) begin
      lim  = (reg_max_payload < PAYLOAD_DEPTH) ? reg_max_payload : PAYLOAD_DEPTH;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(8'($urandom), pick_len(lim), 1'b0, 1'b0);
      end else if (pick < 75) begin
        send_frame(8'($urandom), pick_len(lim), 1'b1, 1'b0);
      end else if (pick < 82) begin
        send_oversize(8'($urandom_range(lim + 1, 255)));
      end else if (pick < 89) begin
        send_item(REQ_BYTE, reg_header);
        repeat ($urandom_range(0, 3)) send_item(REQ_BYTE, 8'($urandom));
        // only wait out short timeouts; a long one just runs into the next frame
        if (reg_timeout <= 200) begin
          repeat (reg_timeout + 1) send_tick();
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_tick();
          end else begin
            send_item(REQ_BYTE, 8'($urandom));
          end
        end
      end
      if ($urandom_range(0, 29) == 0) begin
        pause_until_done();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: empty frame, a one-byte frame of all ones, a checksum
  // mismatch, a tick while hunting, and lengths over the limit, one of them
  // too wide for the length field.
  task automatic test_default_frames();
    sender_gaps = 1'b1;
    send_frame(8'h00, 0, 1'b0, 1'b0);
    send_frame(8'hFF, 1, 1'b0, 1'b1);
    send_frame(8'h5A, 0, 1'b1, 1'b0);
    send_tick();
    send_oversize(8'hFF);
    send_oversize(8'(PAYLOAD_DEPTH + 1));
  endtask

  // Timeout of one: one tick between bytes is tolerated, the second is
  // not. Time out in the type, length and payload phases.
  task automatic test_timeouts();
    write_reg(REG_TIMEOUT_MS, 16'd1);
    send_item(REQ_BYTE, reg_header);
    send_tick();
    send_tick();
    send_item(REQ_BYTE, reg_header);
    send_tick();
    send_item(REQ_BYTE, 8'h3C);
    send_tick();
    send_tick();
    send_item(REQ_BYTE, reg_header);
    send_item(REQ_BYTE, 8'hC3);
    send_item(REQ_BYTE, 8'd2);
    send_item(REQ_BYTE, 8'h11);
    send_tick();
    send_tick();
  endtask

  // Hunt right up to the limit, then offer the header value on the byte
  // that goes over it: still a bad header. A clean frame must follow.
  task automatic test_hunt_limit();
    logic [BYTE_W-1:0] b;
    sender_gaps = 1'b0;
    repeat (HUNT_LIMIT - hunt_seen) begin
      do b = 8'($urandom); while (b == reg_header);
      send_item(REQ_BYTE, b);
    end
    send_item(REQ_BYTE, reg_header);
    send_frame(8'h81, 0, 1'b0, 1'b0);
    sender_gaps = 1'b1;
  endtask

  // Extremes of every register (timeout 1 at the low end), then two partly random settings.
  task automatic test_register_sweep();
    apply_settings(6'd0, 16'd1, 8'h00);
    run_traffic(50);
    sender_gaps = 1'b0;
    apply_settings(6'd63, 16'hFFFF, 8'hFF);
    run_traffic(50);
    sender_gaps = 1'b1;
    apply_settings(6'd32, 16'($urandom_range(2, 40)), 8'($urandom));
    run_traffic(50);
    apply_settings(6'($urandom_range(1, 31)), 16'($urandom_range(41, 200)), 8'hAA);
    run_traffic(50);
  endtask

  task automatic test_mixed_traffic();
    apply_settings(RST_MAX_PAYLOAD, RST_TIMEOUT_MS, RST_HEADER_BYTE);
    run_traffic(200);
  endtask

  // --------------------------------------------------------------------------
  // Receiver side and checking
  // --------------------------------------------------------------------------

  // Stall on a rotating pattern; swap it now and then, sometimes for a
  // stretch with no stall at all. Bit 0 is forced so no stall runs long.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      ready_hold    = $urandom_range(16, 96);
    end
    ready_hold--;
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest queued expectation.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d cmd_type %0d", status, cmd_type);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, status);
        compare_field("cmd_type", want.cmd, cmd_type);
        compare_field("payload_len", want.len, payload_len);
        compare_field("byte_index", want.idx, byte_index);
        compare_field("payload_byte", want.data, payload_byte);
        compare_field("rx_checksum", want.chk, rx_checksum);
        compare_field("last", want.fin, last);
      end
    end
  end

  // Abandon the run once nothing at all has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("crc8_frame_receiver_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_frames();
    test_timeouts();
    test_hunt_limit();
    test_register_sweep();
    test_mixed_traffic();
    // drain the last results, then give any stray transfer time to show
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("crc8_frame_receiver_core verification clean");
    end else begin
      $display("crc8_frame_receiver_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/crc8fr_pkg.sv
rtl/crc8fr_ram.sv
rtl/crc8fr_ctrl.sv
rtl/crc8fr_dp.sv
rtl/crc8_frame_receiver_core.sv
bench/crc8_frame_receiver_tb.sv
